// ----- design/bsc_pkg.sv -----
// Package: shared types and constants for the barometric compensation pipeline.
// Depends on nothing.
`default_nettype none
package bsc_pkg;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_press;
  } bsc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_decicelsius;
    logic [17:0]        pressure_pa;
    logic [1:0]         error_code;
  } bsc_out_t;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrTemp  = 2'd1,
    ErrPress = 2'd2
  } bsc_err_e;

  typedef enum logic [1:0] {
    RegAc123 = 2'd0,
    RegAc456 = 2'd1,
    RegB12   = 2'd2,
    RegMcMd  = 2'd3
  } bsc_reg_e;

  localparam int unsigned DivW = 32;

  localparam logic [31:0] TOff    = 32'd4000;
  localparam logic [31:0] B4Off   = 32'd32768;
  localparam logic [31:0] B7Scale = 32'd50000;
  localparam logic [31:0] C1      = 32'd3038;
  localparam logic [31:0] C2      = 32'hFFFF_E343;
  localparam logic [31:0] C3      = 32'd3791;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

// ----- design/bsc_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each division. Uses bsc_pkg.
`default_nettype none
module bsc_div
  import bsc_pkg::*;
#(
  parameter int unsigned SW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [DivW-1:0] num_i,
  input  wire logic [DivW-1:0] den_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [DivW-1:0]      quo_o,
  output logic [SW-1:0]        side_o
);

  logic [DivW-1:0] vld_q;
  logic [DivW-1:0] rem_q  [DivW];
  logic [DivW-1:0] num_q  [DivW];
  logic [DivW-1:0] quo_q  [DivW];
  logic [DivW-1:0] den_q  [DivW];
  logic [SW-1:0]   side_q [DivW];

  logic [DivW-1:0] rem_d  [DivW];
  logic [DivW-1:0] num_d  [DivW];
  logic [DivW-1:0] quo_d  [DivW];
  logic [DivW-1:0] den_d  [DivW];
  logic [SW-1:0]   side_d [DivW];

  always_comb begin
    logic [DivW-1:0] rem_in, num_in, quo_in, den_in;
    logic [DivW:0]   trial;
    for (int k = 0; k < DivW; k++) begin
      if (k == 0) begin
        rem_in    = '0;
        num_in    = num_i;
        quo_in    = '0;
        den_in    = den_i;
        side_d[k] = side_i;
      end else begin
        rem_in    = rem_q[k-1];
        num_in    = num_q[k-1];
        quo_in    = quo_q[k-1];
        den_in    = den_q[k-1];
        side_d[k] = side_q[k-1];
      end
      trial    = {rem_in, num_in[DivW-1]};
      den_d[k] = den_in;
      num_d[k] = {num_in[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_in}) begin
        rem_d[k] = DivW'(trial - {1'b0, den_in});
        quo_d[k] = {quo_in[DivW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[DivW-1:0];
        quo_d[k] = {quo_in[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivW; k++) begin
      rem_q[k]  <= rem_d[k];
      num_q[k]  <= num_d[k];
      quo_q[k]  <= quo_d[k];
      den_q[k]  <= den_d[k];
      side_q[k] <= side_d[k];
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quo_o   = quo_q[DivW-1];
  assign side_o  = side_q[DivW-1];

endmodule
`default_nettype wire

// ----- design/barometric_sensor_compensation_top.sv -----
// Top level: calibration registers on an APB-style port and the compensation pipeline.
// Depends on bsc_pkg and bsc_div.
// Pipeline: 2*32 divider stages plus 14 register stages between start and done.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Reset: asynchronous active low, clears calibration registers and all valid bits.
`default_nettype none
module barometric_sensor_compensation_top
  import bsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bsc_in_t  operands_i,
  output logic          done_o,
  output bsc_out_t      result_o,
  input  wire logic     psel,
  input  wire logic     penable,
  input  wire logic     pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b12_q, mcmd_q;
  bsc_reg_e    ridx;

  assign ridx   = bsc_reg_e'(paddr[4:3]);
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac123_q <= '0;
      ac456_q <= '0;
      b12_q   <= '0;
      mcmd_q  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        RegAc123: ac123_q <= pwdata[47:0];
        RegAc456: ac456_q <= pwdata[47:0];
        RegB12:   b12_q   <= pwdata[31:0];
        RegMcMd:  mcmd_q  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegAc123: prdata = {16'd0, ac123_q};
      RegAc456: prdata = {16'd0, ac456_q};
      RegB12:   prdata = {32'd0, b12_q};
      RegMcMd:  prdata = {32'd0, mcmd_q};
      default:  prdata = '0;
    endcase
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = 32'($signed(ac123_q[47:32]));
  assign ac2 = 32'($signed(ac123_q[31:16]));
  assign ac3 = 32'($signed(ac123_q[15:0]));
  assign ac4 = {16'd0, ac456_q[47:32]};
  assign ac5 = {16'd0, ac456_q[31:16]};
  assign ac6 = {16'd0, ac456_q[15:0]};
  assign b1  = 32'($signed(b12_q[31:16]));
  assign b2  = 32'($signed(b12_q[15:0]));
  assign mc  = 32'($signed(mcmd_q[31:16]));
  assign md  = 32'($signed(mcmd_q[15:0]));

  // Stage 1: input word
  logic        v1_q;
  bsc_in_t     in1_q;
  // Stage 2: first product
  logic        v2_q;
  logic [31:0] pr2_q;
  logic [15:0] up2_q;
  // Stage 3: temperature divider operands
  logic        v3_q;
  logic [31:0] n3_q, d3_q, x13_q;
  logic [15:0] up3_q;
  logic        neg3_q, e13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] x1, dd, nn;
    in1_q <= operands_i;
    pr2_q <= 32'(({16'd0, in1_q.raw_temp} - ac6) * ac5);
    up2_q <= in1_q.raw_press;
    x1 = asr32(pr2_q, 15);
    dd = x1 + md;
    nn = mc << 11;
    x13_q  <= x1;
    up3_q  <= up2_q;
    e13_q  <= (dd == 32'd0);
    neg3_q <= nn[31] ^ dd[31];
    n3_q   <= nn[31] ? 32'd0 - nn : nn;
    d3_q   <= dd[31] ? 32'd0 - dd : dd;
  end

  localparam int unsigned S1W = 50;
  logic           v4;
  logic [31:0]    q4;
  logic [S1W-1:0] s4;

  bsc_div #(.SW(S1W)) u_div_t (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .num_i   (n3_q),
    .den_i   (d3_q),
    .side_i  ({x13_q, up3_q, neg3_q, e13_q}),
    .valid_o (v4),
    .quo_o   (q4),
    .side_o  (s4)
  );

  // Stage 5..11: temperature rounding and pressure coefficient chain
  logic [6:0]  v_q;
  logic [31:0] b55_q;
  logic [15:0] up5_q, up6_q, up7_q, up8_q, up9_q;
  logic        e15_q, e16_q, e17_q, e18_q, e19_q, e110_q, e111_q;
  logic signed [15:0] t6_q, t7_q, t8_q, t9_q, t10_q, t11_q;
  logic [31:0] sqp6_q, a2p6_q, a3p6_q;
  logic [31:0] sq7_q, xa7_q, xc7_q;
  logic [31:0] b2s8_q, b1s8_q, xa8_q, xc8_q;
  logic [31:0] b39_q, x39_q;
  logic [31:0] b4p10_q, b7_10_q;
  logic [31:0] n11_q, d11_q;
  logic        sh11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], v4};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] x2, b6, tt, x3, v3, b4, b7;
    x2 = s4[1] ? 32'd0 - q4 : q4;
    b55_q <= s4[49:18] + x2;
    up5_q <= s4[17:2];
    e15_q <= s4[0];

    tt = asr32(b55_q + 32'd8, 4);
    if ($signed(tt) > 32'sd32767) t6_q <= 16'sd32767;
    else if ($signed(tt) < -32'sd32768) t6_q <= -16'sd32768;
    else t6_q <= tt[15:0];
    b6 = b55_q - TOff;
    sqp6_q <= 32'(b6 * b6);
    a2p6_q <= 32'(ac2 * b6);
    a3p6_q <= 32'(ac3 * b6);
    up6_q  <= up5_q;
    e16_q  <= e15_q;

    sq7_q <= asr32(sqp6_q, 12);
    xa7_q <= asr32(a2p6_q, 11);
    xc7_q <= asr32(a3p6_q, 13);
    up7_q <= up6_q;
    e17_q <= e16_q;
    t7_q  <= t6_q;

    b2s8_q <= 32'(b2 * sq7_q);
    b1s8_q <= 32'(b1 * sq7_q);
    xa8_q  <= xa7_q;
    xc8_q  <= xc7_q;
    up8_q  <= up7_q;
    e18_q  <= e17_q;
    t8_q   <= t7_q;

    x3 = asr32(b2s8_q, 11) + xa8_q;
    v3 = (ac1 << 2) + x3 + 32'd2;
    b39_q <= v3[31] ? asr32(v3 + 32'd3, 2) : asr32(v3, 2);
    x39_q <= asr32(xc8_q + asr32(b1s8_q, 16) + 32'd2, 2);
    up9_q <= up8_q;
    e19_q <= e18_q;
    t9_q  <= t8_q;

    b4p10_q <= 32'(ac4 * (x39_q + B4Off));
    b7_10_q <= 32'(({16'd0, up9_q} - b39_q) * B7Scale);
    e110_q  <= e19_q;
    t10_q   <= t9_q;

    b4 = b4p10_q >> 15;
    b7 = b7_10_q;
    d11_q  <= b4;
    sh11_q <= b7[31];
    n11_q  <= b7[31] ? b7 : b7 << 1;
    e111_q <= e110_q;
    t11_q  <= t10_q;
  end

  localparam int unsigned S2W = 19;
  logic           v12;
  logic [31:0]    q12;
  logic [S2W-1:0] s12;

  bsc_div #(.SW(S2W)) u_div_p (
    .clk_i, .rst_ni,
    .valid_i (v_q[6]),
    .num_i   (n11_q),
    .den_i   (d11_q),
    .side_i  ({t11_q, e111_q, d11_q == 32'd0, sh11_q}),
    .valid_o (v12),
    .quo_o   (q12),
    .side_o  (s12)
  );

  // Final stages: pressure correction, error selection and saturation
  logic [3:0]  vf_q;
  logic [31:0] p13_q, p14_q, p15_q;
  logic [31:0] m14_q, m2_14_q, m15_q, x2_15_q;
  logic [2:0]  f13_q, f14_q, f15_q;
  logic signed [15:0] t13_q, t14_q, t15_q;
  bsc_out_t    res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= {vf_q[2:0], v12};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] pa, x1, pp;
    p13_q <= s12[0] ? q12 << 1 : q12;
    t13_q <= s12[18:3];
    f13_q <= s12[2:0];

    pa = asr32(p13_q, 8);
    m14_q   <= 32'(pa * pa);
    m2_14_q <= 32'(C2 * p13_q);
    p14_q   <= p13_q;
    t14_q   <= t13_q;
    f14_q   <= f13_q;

    m15_q   <= 32'(m14_q * C1);
    x2_15_q <= asr32(m2_14_q, 16);
    p15_q   <= p14_q;
    t15_q   <= t14_q;
    f15_q   <= f14_q;

    x1 = asr32(m15_q, 16);
    pp = p15_q + asr32(x1 + x2_15_q + C3, 4);
    if (f15_q[2]) begin
      res_q.temperature_decicelsius <= '0;
      res_q.pressure_pa             <= '0;
      res_q.error_code              <= ErrTemp;
    end else if (f15_q[1]) begin
      res_q.temperature_decicelsius <= t15_q;
      res_q.pressure_pa             <= '0;
      res_q.error_code              <= ErrPress;
    end else begin
      res_q.temperature_decicelsius <= t15_q;
      if (pp[31]) res_q.pressure_pa <= '0;
      else if (pp > 32'd262143) res_q.pressure_pa <= 18'h3FFFF;
      else res_q.pressure_pa <= pp[17:0];
      res_q.error_code <= ErrNone;
    end
  end

  assign done_o   = vf_q[3];
  assign result_o = res_q;

endmodule
`default_nettype wire
